### rtl/core/deadline_ordered_message_queue_defines.svh
// Assertion macros for the deadline ordered message queue.
// Each macro expands to a labelled concurrent assertion, or to nothing.
`ifndef DEADLINE_ORDERED_MESSAGE_QUEUE_DEFINES_SVH
`define DEADLINE_ORDERED_MESSAGE_QUEUE_DEFINES_SVH
`ifndef ASSERT_OFF
`define DMQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DMQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DMQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define DMQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/core/dmq_pkg.sv
`default_nettype none
package dmq_pkg;
	localparam int DEPTH_DEF = 16;
	localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

	localparam logic [3:0] ST_QUEUED       = 4'd0;
	localparam logic [3:0] ST_REJ_CLOSED   = 4'd1;
	localparam logic [3:0] ST_REJ_FULL     = 4'd2;
	localparam logic [3:0] ST_DELIVERED    = 4'd3;
	localparam logic [3:0] ST_NOT_DUE      = 4'd4;
	localparam logic [3:0] ST_EMPTY        = 4'd5;
	localparam logic [3:0] ST_CLOSED_END   = 4'd6;
	localparam logic [3:0] ST_REMOVED      = 4'd7;
	localparam logic [3:0] ST_NONE_REMOVED = 4'd8;
	localparam logic [3:0] ST_QUIT_DONE    = 4'd9;

	typedef enum logic [2:0] {
		OP_ENQ    = 3'd0,
		OP_FRONT  = 3'd1,
		OP_POLL   = 3'd2,
		OP_REMOVE = 3'd3,
		OP_QUIT   = 3'd4
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] code;
		logic [31:0] wrd;
		logic [31:0] lng;
		logic [31:0] due;
		logic [31:0] now;
	} cmd_t;

	typedef struct packed {
		logic [31:0] due;
		logic [15:0] code;
		logic [31:0] wrd;
		logic [31:0] lng;
	} entry_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_INS_RD,
		BK_INS_CMP,
		BK_INS_FIRST,
		BK_POLL_RD,
		BK_POLL_CMP,
		BK_REM_RD,
		BK_REM_CMP,
		BK_QUIT_RD,
		BK_QUIT_CMP
	} back_state_t;
endpackage
`default_nettype wire

### rtl/core/dmq_front.sv
`default_nettype none
module dmq_front (
	input  wire logic               in_valid,
	input  wire logic               fifo_full,
	input  wire logic [2:0]         kind,
	input  wire logic [15:0]        message_code,
	input  wire logic signed [31:0] word_param,
	input  wire logic signed [31:0] long_param,
	input  wire logic [31:0]        delay,
	input  wire logic [31:0]        now_time,
	output logic                    in_stall,
	output logic                    push,
	output dmq_pkg::cmd_t           cmd
);
	dmq_pkg::op_t op;
	logic [31:0]  base;
	logic [32:0]  sum;
	logic         known;

	// kinds 5..7 are swallowed with no transaction downstream
	always_comb begin
		known = 1'b1;
		case (kind)
			dmq_pkg::OP_ENQ:    op = dmq_pkg::OP_ENQ;
			dmq_pkg::OP_FRONT:  op = dmq_pkg::OP_FRONT;
			dmq_pkg::OP_POLL:   op = dmq_pkg::OP_POLL;
			dmq_pkg::OP_REMOVE: op = dmq_pkg::OP_REMOVE;
			dmq_pkg::OP_QUIT:   op = dmq_pkg::OP_QUIT;
			default: begin
				op    = dmq_pkg::OP_POLL;
				known = 1'b0;
			end
		endcase
	end

	assign base = (now_time == 32'd0) ? 32'd1 : now_time;
	assign sum  = {1'b0, base} + {1'b0, delay};

	assign cmd.op   = op;
	assign cmd.code = message_code;
	assign cmd.wrd  = word_param;
	assign cmd.lng  = long_param;
	assign cmd.now  = now_time;
	assign cmd.due  = (op != dmq_pkg::OP_ENQ) ? 32'd0 :
		(sum[32] ? dmq_pkg::TIME_MAX : sum[31:0]);

	assign in_stall = fifo_full;
	assign push     = in_valid && !fifo_full && known;
endmodule
`default_nettype wire

### rtl/core/dmq_fifo.sv
`default_nettype none
module dmq_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  dmq_pkg::cmd_t      push_cmd,
	output logic               full,
	input  wire logic          pop,
	output logic               cmd_valid,
	output dmq_pkg::cmd_t      cmd
);
	dmq_pkg::cmd_t buf_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wp_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end
endmodule
`default_nettype wire

### rtl/core/dmq_back.sv
`default_nettype none
`include "deadline_ordered_message_queue_defines.svh"
module dmq_back #(
	parameter int DEPTH = dmq_pkg::DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	input  dmq_pkg::cmd_t    cmd_in,
	output logic             cmd_take,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       status,
	output logic [15:0]      out_code,
	output logic [31:0]      out_word,
	output logic [31:0]      out_long,
	output logic [31:0]      wait_time
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	dmq_pkg::back_state_t state_q, state_d;
	dmq_pkg::cmd_t        cmd_q;
	dmq_pkg::entry_t      mem [DEPTH];
	dmq_pkg::entry_t      rd_q, wd, ent_new;
	logic [AW-1:0]        head_q, head_d, ra, wa;
	logic [CW-1:0]        count_q, count_d, k_q, k_d;
	logic [AW-1:0]        idx_q, idx_d;
	logic                 closed_q, closed_d, found_q, found_d, we;
	logic                 out_free, start, last, move, keep;
	logic                 ov_q, ov_d;
	logic [3:0]           st_q, st_d;
	logic [15:0]          oc_q, oc_d;
	logic [31:0]          ow_q, ow_d, ol_q, ol_d, wt_q, wt_d;
	logic [AW-1:0]        head_dec, head_inc;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(i);
		if (s >= (CW+1)'(DEPTH))
			s = s - (CW+1)'(DEPTH);
		return s[AW-1:0];
	endfunction

	assign out_free = !ov_q || !out_stall;
	assign start    = (state_q == dmq_pkg::BK_IDLE) && cmd_valid && out_free;
	assign cmd_take = start;
	assign last     = ((CW'(idx_q) + CW'(1)) == count_q);
	assign move     = rd_q.due > cmd_q.due;
	assign keep     = rd_q.due <= cmd_q.now;
	assign ent_new  = '{due: cmd_q.due, code: cmd_q.code, wrd: cmd_q.wrd, lng: cmd_q.lng};
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dmq_pkg::BK_IDLE: begin
				if (start) begin
					case (cmd_in.op)
						dmq_pkg::OP_ENQ:
							if (!closed_q && count_q != CW'(DEPTH) && count_q != '0)
								state_d = dmq_pkg::BK_INS_RD;
						dmq_pkg::OP_POLL:
							if (count_q != '0)
								state_d = dmq_pkg::BK_POLL_RD;
						dmq_pkg::OP_REMOVE:
							if (count_q != '0)
								state_d = dmq_pkg::BK_REM_RD;
						dmq_pkg::OP_QUIT:
							if (!closed_q && count_q != '0)
								state_d = dmq_pkg::BK_QUIT_RD;
						default: state_d = dmq_pkg::BK_IDLE;
					endcase
				end
			end
			dmq_pkg::BK_INS_RD:  state_d = dmq_pkg::BK_INS_CMP;
			dmq_pkg::BK_INS_CMP: begin
				if (!move)
					state_d = dmq_pkg::BK_IDLE;
				else if (idx_q == '0)
					state_d = dmq_pkg::BK_INS_FIRST;
				else
					state_d = dmq_pkg::BK_INS_RD;
			end
			dmq_pkg::BK_INS_FIRST: state_d = dmq_pkg::BK_IDLE;
			dmq_pkg::BK_POLL_RD:   state_d = dmq_pkg::BK_POLL_CMP;
			dmq_pkg::BK_POLL_CMP:  state_d = dmq_pkg::BK_IDLE;
			dmq_pkg::BK_REM_RD:    state_d = dmq_pkg::BK_REM_CMP;
			dmq_pkg::BK_REM_CMP:
				state_d = last ? dmq_pkg::BK_IDLE : dmq_pkg::BK_REM_RD;
			dmq_pkg::BK_QUIT_RD:   state_d = dmq_pkg::BK_QUIT_CMP;
			dmq_pkg::BK_QUIT_CMP:
				state_d = (keep && !last) ? dmq_pkg::BK_QUIT_RD : dmq_pkg::BK_IDLE;
			default: state_d = dmq_pkg::BK_IDLE;
		endcase
	end

	// datapath and result
	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		closed_d = closed_q;
		idx_d    = idx_q;
		k_d      = k_q;
		found_d  = found_q;
		we       = 1'b0;
		wa       = phys(head_q, '0);
		wd       = ent_new;
		ra       = phys(head_q, CW'(idx_q));
		ov_d     = ov_q && out_stall;
		st_d     = st_q;
		oc_d     = oc_q;
		ow_d     = ow_q;
		ol_d     = ol_q;
		wt_d     = wt_q;
		case (state_q)
			dmq_pkg::BK_IDLE: begin
				if (start) begin
					oc_d = '0;
					ow_d = '0;
					ol_d = '0;
					wt_d = '0;
					idx_d   = '0;
					k_d     = '0;
					found_d = 1'b0;
					case (cmd_in.op)
						dmq_pkg::OP_ENQ, dmq_pkg::OP_FRONT: begin
							if (closed_q) begin
								ov_d = 1'b1;
								st_d = dmq_pkg::ST_REJ_CLOSED;
							end else if (count_q == CW'(DEPTH)) begin
								ov_d = 1'b1;
								st_d = dmq_pkg::ST_REJ_FULL;
							end else if (cmd_in.op == dmq_pkg::OP_FRONT || count_q == '0) begin
								we   = 1'b1;
								wd   = '{due: cmd_in.due, code: cmd_in.code,
									wrd: cmd_in.wrd, lng: cmd_in.lng};
								if (cmd_in.op == dmq_pkg::OP_FRONT) begin
									wa     = head_dec;
									head_d = head_dec;
								end
								count_d = count_q + CW'(1);
								ov_d    = 1'b1;
								st_d    = dmq_pkg::ST_QUEUED;
							end else begin
								idx_d = AW'(count_q - CW'(1));
							end
						end
						dmq_pkg::OP_POLL: begin
							if (count_q == '0) begin
								ov_d = 1'b1;
								st_d = closed_q ? dmq_pkg::ST_CLOSED_END : dmq_pkg::ST_EMPTY;
								wt_d = dmq_pkg::TIME_MAX;
							end
						end
						dmq_pkg::OP_REMOVE: begin
							if (count_q == '0) begin
								ov_d = 1'b1;
								st_d = dmq_pkg::ST_NONE_REMOVED;
							end
						end
						dmq_pkg::OP_QUIT: begin
							closed_d = 1'b1;
							if (closed_q || count_q == '0) begin
								ov_d = 1'b1;
								st_d = dmq_pkg::ST_QUIT_DONE;
							end
						end
						default: ov_d = ov_q && out_stall;
					endcase
				end
			end
			dmq_pkg::BK_INS_CMP: begin
				we = 1'b1;
				wa = phys(head_q, CW'(idx_q) + CW'(1));
				if (move) begin
					wd = rd_q;
					if (idx_q != '0)
						idx_d = idx_q - AW'(1);
				end else begin
					count_d = count_q + CW'(1);
					ov_d    = 1'b1;
					st_d    = dmq_pkg::ST_QUEUED;
				end
			end
			dmq_pkg::BK_INS_FIRST: begin
				we      = 1'b1;
				count_d = count_q + CW'(1);
				ov_d    = 1'b1;
				st_d    = dmq_pkg::ST_QUEUED;
			end
			dmq_pkg::BK_POLL_CMP: begin
				ov_d = 1'b1;
				if (cmd_q.now >= rd_q.due) begin
					st_d    = dmq_pkg::ST_DELIVERED;
					oc_d    = rd_q.code;
					ow_d    = rd_q.wrd;
					ol_d    = rd_q.lng;
					head_d  = head_inc;
					count_d = count_q - CW'(1);
				end else begin
					wt_d = rd_q.due - cmd_q.now;
					st_d = closed_q ? dmq_pkg::ST_CLOSED_END : dmq_pkg::ST_NOT_DUE;
				end
			end
			dmq_pkg::BK_REM_CMP: begin
				wd = rd_q;
				wa = phys(head_q, k_q);
				if (rd_q.code == cmd_q.code) begin
					found_d = 1'b1;
				end else begin
					we  = 1'b1;
					k_d = k_q + CW'(1);
				end
				if (last) begin
					count_d = k_d;
					ov_d    = 1'b1;
					st_d    = found_d ? dmq_pkg::ST_REMOVED : dmq_pkg::ST_NONE_REMOVED;
				end else begin
					idx_d = idx_q + AW'(1);
				end
			end
			dmq_pkg::BK_QUIT_CMP: begin
				if (!keep) begin
					count_d = CW'(idx_q);
					ov_d    = 1'b1;
					st_d    = dmq_pkg::ST_QUIT_DONE;
				end else if (last) begin
					ov_d = 1'b1;
					st_d = dmq_pkg::ST_QUIT_DONE;
				end else begin
					idx_d = idx_q + AW'(1);
				end
			end
			default: ov_d = ov_q && out_stall;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rd_q <= mem[ra];
		if (start)
			cmd_q <= cmd_in;
		st_q <= st_d;
		oc_q <= oc_d;
		ow_q <= ow_d;
		ol_q <= ol_d;
		wt_q <= wt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= dmq_pkg::BK_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			closed_q <= 1'b0;
			idx_q    <= '0;
			k_q      <= '0;
			found_q  <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			count_q  <= count_d;
			closed_q <= closed_d;
			idx_q    <= idx_d;
			k_q      <= k_d;
			found_q  <= found_d;
			ov_q     <= ov_d;
		end
	end

	assign out_valid = ov_q;
	assign status    = st_q;
	assign out_code  = oc_q;
	assign out_word  = ow_q;
	assign out_long  = ol_q;
	assign wait_time = wt_q;

	`DMQ_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH), "entry count above depth")
	`DMQ_ASSERT(a_busy_out_free, clk, arst_n, (state_q != dmq_pkg::BK_IDLE) |-> !ov_q, "result pending while busy")
	`DMQ_ASSERT(a_closed_sticky, clk, arst_n, closed_q |=> closed_q, "queue reopened")
endmodule
`default_nettype wire

### rtl/core/deadline_ordered_message_queue.sv
`default_nettype none
// Deadline ordered message queue: up to DEPTH messages sorted by due time, save front enqueues.
// Input channel (in_valid / in_stall): one command transaction per item -
//   delayed enqueue, front enqueue, poll, remove by code, quit. Kinds 5..7
//   are accepted and dropped with no result.
// Output channel (out_valid / out_stall): one result transaction per command.
// The front decodes the command and works out the saturating due time, then
// parks it in a two-entry command queue; the back walks the entry memory.
// Rejects, front enqueue and empty poll/remove/quit are answered straight from
//   idle; poll reads the head entry; delayed enqueue walks from the tail until
//   it finds its place; remove walks every entry; quit walks from the head
//   until the first entry not yet due.
// Each entry visited takes a registered memory read state, then a compare and
// write-back state. Throughput is one command per back-end run.
// Reset empties the queue and reopens it; the memory itself is not cleared.
// A stalled result holds the output register; the command queue keeps taking
// input until both of its slots are full, then in_stall rises.
module deadline_ordered_message_queue #(
	parameter int DEPTH = dmq_pkg::DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         kind,
	input  wire logic [15:0]        message_code,
	input  wire logic signed [31:0] word_param,
	input  wire logic signed [31:0] long_param,
	input  wire logic [31:0]        delay,
	input  wire logic [31:0]        now_time,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [3:0]              status,
	output logic [15:0]             out_code,
	output logic signed [31:0]      out_word,
	output logic signed [31:0]      out_long,
	output logic [31:0]             wait_time
);
	dmq_pkg::cmd_t front_cmd, back_cmd;
	logic          push, fifo_full, cmd_valid, cmd_take;
	logic [31:0]   ow, ol;

	// decode and due-time arithmetic
	dmq_front u_front (
		.in_valid     (in_valid),
		.fifo_full    (fifo_full),
		.kind         (kind),
		.message_code (message_code),
		.word_param   (word_param),
		.long_param   (long_param),
		.delay        (delay),
		.now_time     (now_time),
		.in_stall     (in_stall),
		.push         (push),
		.cmd          (front_cmd)
	);

	// decouples the front from the back end's walk
	dmq_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (front_cmd),
		.full      (fifo_full),
		.pop       (cmd_take),
		.cmd_valid (cmd_valid),
		.cmd       (back_cmd)
	);

	// sorted store as a ring in one memory, plus result register
	dmq_back #(.DEPTH(DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_in    (back_cmd),
		.cmd_take  (cmd_take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.out_code  (out_code),
		.out_word  (ow),
		.out_long  (ol),
		.wait_time (wait_time)
	);

	assign out_word = ow;
	assign out_long = ol;
endmodule
`default_nettype wire

### verif/dmq_checker.sv
`default_nettype none
module dmq_checker #(
	parameter int DEPTH = dmq_pkg::DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic [2:0]         kind,
	input  wire logic [15:0]        message_code,
	input  wire logic signed [31:0] word_param,
	input  wire logic signed [31:0] long_param,
	input  wire logic [31:0]        delay,
	input  wire logic [31:0]        now_time,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic [3:0]         status,
	input  wire logic [15:0]        out_code,
	input  wire logic signed [31:0] out_word,
	input  wire logic signed [31:0] out_long,
	input  wire logic [31:0]        wait_time,
	output int                      errors,
	output int                      pending,
	output logic                    moved
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [3:0]  st;
		logic [15:0] code;
		logic [31:0] wrd;
		logic [31:0] lng;
		logic [31:0] wt;
	} outcome_t;

	dmq_pkg::entry_t sched[$];
	logic            shut;
	outcome_t        due_results[$];

	assign moved   = (in_valid && !in_stall) || (out_valid && !out_stall);

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0h want %0h (t=%0t)", what, got, want, $time);
	endtask

	// Advance the shadow queue by one command; returns 0 when none produced.
	function automatic bit apply_cmd(input logic [2:0] k, input logic [15:0] c,
			input logic [31:0] w, input logic [31:0] l, input logic [31:0] dly,
			input logic [31:0] now, output outcome_t r);
		dmq_pkg::entry_t e;
		logic [31:0] base;
		int pos;
		bit hit;
		dmq_pkg::entry_t kept[$];
		r = '0;
		case (k)
			dmq_pkg::OP_ENQ, dmq_pkg::OP_FRONT: begin
				if (shut)
					r.st = dmq_pkg::ST_REJ_CLOSED;
				else if (sched.size() >= DEPTH)
					r.st = dmq_pkg::ST_REJ_FULL;
				else begin
					e.code = c;
					e.wrd = w;
					e.lng = l;
					e.due = '0;
					pos = 0;
					if (k == dmq_pkg::OP_ENQ) begin
						base = (now == 0) ? 32'd1 : now;
						e.due = (dly > dmq_pkg::TIME_MAX - base) ? dmq_pkg::TIME_MAX :
							base + dly;
						while (pos < sched.size() && sched[pos].due <= e.due)
							pos++;
					end
					sched.insert(pos, e);
					r.st = dmq_pkg::ST_QUEUED;
				end
			end
			dmq_pkg::OP_POLL: begin
				if (sched.size() > 0 && now >= sched[0].due) begin
					e = sched.pop_front();
					r.st = dmq_pkg::ST_DELIVERED;
					r.code = e.code;
					r.wrd = e.wrd;
					r.lng = e.lng;
				end else begin
					r.wt = (sched.size() > 0) ? sched[0].due - now : dmq_pkg::TIME_MAX;
					r.st = shut ? dmq_pkg::ST_CLOSED_END :
						(sched.size() > 0) ? dmq_pkg::ST_NOT_DUE : dmq_pkg::ST_EMPTY;
				end
			end
			dmq_pkg::OP_REMOVE: begin
				hit = 0;
				foreach (sched[i])
					if (sched[i].code == c) hit = 1;
					else kept.push_back(sched[i]);
				sched = kept;
				r.st = hit ? dmq_pkg::ST_REMOVED : dmq_pkg::ST_NONE_REMOVED;
			end
			dmq_pkg::OP_QUIT: begin
				if (!shut) begin
					shut = 1;
					pos = 0;
					while (pos < sched.size() && sched[pos].due <= now)
						pos++;
					while (sched.size() > pos)
						void'(sched.pop_back());
				end
				r.st = dmq_pkg::ST_QUIT_DONE;
			end
			default: return 0;
		endcase
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t r, x;
		if (!arst_n) begin
			sched.delete();
			due_results.delete();
			shut = 0;
			errors = 0;
			pending <= 0;
		end else begin
			if (in_valid && !in_stall)
				if (apply_cmd(kind, message_code, word_param, long_param, delay, now_time, r))
					due_results.push_back(r);
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					report("unexpected result status", 32'(status), 32'd0);
				end else begin
					x = due_results.pop_front();
					if (status !== x.st) report("status", 32'(status), 32'(x.st));
					if (out_code !== x.code)
						report("out_code", 32'(out_code), 32'(x.code));
					if (out_word !== x.wrd) report("out_word", out_word, x.wrd);
					if (out_long !== x.lng) report("out_long", out_long, x.lng);
					if (wait_time !== x.wt) report("wait_time", wait_time, x.wt);
				end
			end
			pending <= due_results.size();
		end
	end
endmodule
`default_nettype wire

### verif/tb.sv
`default_nettype none
// Stimulus and verdict for the deadline ordered message queue.
// The checker beside the block does all prediction and comparison.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH     = dmq_pkg::DEPTH_DEF;
	localparam int N_RANDOM  = 1930;
	localparam int IDLE_LIM  = 20000; // cycles with no transaction at all

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_stall;
	logic [2:0]         kind = '0;
	logic [15:0]        message_code = '0;
	logic signed [31:0] word_param = '0;
	logic signed [31:0] long_param = '0;
	logic [31:0]        delay = '0;
	logic [31:0]        now_time = '0;
	logic               out_valid;
	logic               out_stall = 0;
	logic [3:0]         status;
	logic [15:0]        out_code;
	logic signed [31:0] out_word;
	logic signed [31:0] out_long;
	logic [31:0]        wait_time;

	int   errors, pending;
	logic moved;
	bit   calm = 0;       // no idling on either side
	bit   hold_rx = 0;    // long receiver hold-off requested
	int   quiet = 0;
	logic [31:0] clock_ms = 0; // rolling time seen by the block

	always #2 clk = ~clk;

	deadline_ordered_message_queue #(.DEPTH(DEPTH)) dut (.*);

	dmq_checker #(.DEPTH(DEPTH)) chk (.*);

	// Watchdog: ends the run after a long spell with nothing accepted.
	always @(posedge clk) begin
		quiet <= moved ? 0 : quiet + 1;
		if (quiet >= IDLE_LIM) begin
			$display("deadline_ordered_message_queue regression: fail");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold while hold_rx is set.
	always @(posedge clk) begin
		int n;
		if (hold_rx) begin
			out_stall <= 1;
			for (n = 0; n < 300; n++) @(posedge clk);
			hold_rx <= 0;
			out_stall <= 0;
		end else
			out_stall <= !calm && ($urandom_range(99) < 12);
	end

	// One transaction; holds the payload until accepted. Random gaps ahead of it.
	task automatic send(input logic [2:0] k, input logic [15:0] c, input logic [31:0] w,
			input logic [31:0] l, input logic [31:0] d, input logic [31:0] now);
		while (!calm && $urandom_range(99) < 12) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		kind <= k;
		message_code <= c;
		word_param <= w;
		long_param <= l;
		delay <= d;
		now_time <= now;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain;
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Mostly well-formed traffic around a rolling clock; small codes so removes hit.
	task automatic random_item;
		logic [2:0]  k;
		logic [31:0] d, now;
		int pick;
		pick = $urandom_range(99);
		if (pick < 40) k = dmq_pkg::OP_ENQ;
		else if (pick < 50) k = dmq_pkg::OP_FRONT;
		else if (pick < 85) k = dmq_pkg::OP_POLL;
		else if (pick < 93) k = dmq_pkg::OP_REMOVE;
		else if (pick < 96) k = dmq_pkg::OP_QUIT;
		else k = 3'($urandom_range(7, 5));
		clock_ms += $urandom_range(20);
		now = ($urandom_range(19) == 0) ? $urandom : clock_ms;
		case ($urandom_range(9))
			0: d = $urandom;
			1: d = dmq_pkg::TIME_MAX;
			default: d = $urandom_range(60);
		endcase
		send(k, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7)),
			$urandom, $urandom, d, now);
	endtask

	initial begin
		int i;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty poll, extremes, time zero, saturation, front, full, removes.
		send(dmq_pkg::OP_POLL, 0, 0, 0, 0, 0);
		send(dmq_pkg::OP_REMOVE, 16'hFFFF, 0, 0, 0, 0);
		send(dmq_pkg::OP_ENQ, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 5, 0);
		send(dmq_pkg::OP_ENQ, 16'h0000, 32'hFFFF_FFFF, 32'h0000_0000, dmq_pkg::TIME_MAX, 100);
		send(dmq_pkg::OP_ENQ, 16'h1234, 1, 2, 32'hFFFF_FFFE, 0);
		send(dmq_pkg::OP_FRONT, 16'h00AA, 3, 4, 0, 0);
		send(dmq_pkg::OP_POLL, 0, 0, 0, 0, 0);
		send(dmq_pkg::OP_POLL, 0, 0, 0, 0, 3);
		send(dmq_pkg::OP_POLL, 0, 0, 0, 0, 6);
		for (i = 0; i < DEPTH; i++)
			send(dmq_pkg::OP_ENQ, 16'(i % 3), i, -i, 10, 50);
		send(dmq_pkg::OP_FRONT, 7, 0, 0, 0, 0);
		send(3'd5, 0, 0, 0, 0, 0);
		send(3'd7, 0, 0, 0, 0, 0);
		send(dmq_pkg::OP_REMOVE, 1, 0, 0, 0, 0);
		send(dmq_pkg::OP_QUIT, 0, 0, 0, 0, 60);
		send(dmq_pkg::OP_ENQ, 9, 0, 0, 1, 1);
		send(dmq_pkg::OP_POLL, 0, 0, 0, 0, 61);
		send(dmq_pkg::OP_QUIT, 0, 0, 0, 0, 0);
		drain();

		// Closed state is permanent; further traffic exercises closed polls and removes.
		for (i = 0; i < N_RANDOM; i++) begin
			if (i == 300) begin
				hold_rx <= 1;
				calm = 1;
			end
			if (i == 330) drain();
			if (i == 600) calm = 0;
			if (i == 1000) calm = 1;
			if (i == 1200) calm = 0;
			random_item();
		end
		drain();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("deadline_ordered_message_queue regression: pass");
		else
			$display("deadline_ordered_message_queue regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
